@@ hw/rtl/xor_checked_frame_receiver_macros.svh @@
// Assertion macros used by the frame receiver parser
`ifndef XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Check a property on every clock edge outside reset
`define XCFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define XCFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/xcfr_pkg.sv @@
// Types, codes and reset values for the frame receiver
`timescale 1ns / 1ps

package xcfr_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SEQ    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_TOKEN  = 3'd4,
    PH_DATA   = 3'd5,
    PH_CKSUM  = 3'd6
  } phase_t;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_DEV_CKSUM = 3'd2;
  localparam logic [2:0] ERR_BAD_CKSUM = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT   = 3'd4;

  localparam logic [2:0] CFG_START_BYTE  = 3'd0;
  localparam logic [2:0] CFG_TOKEN_BYTE  = 3'd1;
  localparam logic [2:0] CFG_CKSUM_ERROR = 3'd2;
  localparam logic [2:0] CFG_MAX_PAYLOAD = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT     = 3'd4;

  localparam logic [7:0]  RST_START_BYTE  = 8'd27;
  localparam logic [7:0]  RST_TOKEN_BYTE  = 8'd14;
  localparam logic [7:0]  RST_CKSUM_ERROR = 8'd176;
  localparam logic [15:0] RST_MAX_PAYLOAD = 16'd275;
  localparam logic [15:0] RST_TIMEOUT     = 16'd10;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  token_byte;
    logic [7:0]  cksum_error_answer;
    logic [15:0] max_payload;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [2:0]  error_code;
    logic [15:0] frame_length;
    logic        last;
  } result_t;

endpackage

@@ hw/rtl/xcfr_cfg_regs.sv @@
// Configuration register bank of the frame receiver
`timescale 1ns / 1ps

module xcfr_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output xcfr_pkg::cfg_t      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte         <= xcfr_pkg::RST_START_BYTE;
      cfg.token_byte         <= xcfr_pkg::RST_TOKEN_BYTE;
      cfg.cksum_error_answer <= xcfr_pkg::RST_CKSUM_ERROR;
      cfg.max_payload        <= xcfr_pkg::RST_MAX_PAYLOAD;
      cfg.timeout_ticks      <= xcfr_pkg::RST_TIMEOUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        xcfr_pkg::CFG_START_BYTE:  cfg.start_byte         <= cfg_data[7:0];
        xcfr_pkg::CFG_TOKEN_BYTE:  cfg.token_byte         <= cfg_data[7:0];
        xcfr_pkg::CFG_CKSUM_ERROR: cfg.cksum_error_answer <= cfg_data[7:0];
        xcfr_pkg::CFG_MAX_PAYLOAD: cfg.max_payload        <= cfg_data;
        xcfr_pkg::CFG_TIMEOUT:     cfg.timeout_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/xcfr_parser.sv @@
// Frame parsing state machine with checksum, sequence and tick tracking
`timescale 1ns / 1ps
`include "xor_checked_frame_receiver_macros.svh"

module xcfr_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  xcfr_pkg::cfg_t       cfg,
  input  logic                 advance,
  input  logic                 command,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  output xcfr_pkg::result_t    res
);

  xcfr_pkg::phase_t phase, phase_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  expected_sequence, expected_sequence_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] tick_inc;
  logic [15:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= xcfr_pkg::PH_HUNT;
      running_xor       <= '0;
      expected_sequence <= '0;
      declared_length   <= '0;
      payload_count     <= '0;
      tick_count        <= '0;
    end else if (advance) begin
      phase             <= phase_next;
      running_xor       <= running_xor_next;
      expected_sequence <= expected_sequence_next;
      declared_length   <= declared_length_next;
      payload_count     <= payload_count_next;
      tick_count        <= tick_count_next;
    end
  end

  assign tick_inc  = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
  assign count_inc = payload_count + 16'd1;

  always_comb begin
    phase_next             = phase;
    running_xor_next       = running_xor;
    expected_sequence_next = expected_sequence;
    declared_length_next   = declared_length;
    payload_count_next     = payload_count;
    tick_count_next        = tick_count;
    res_valid              = 1'b0;
    res.kind               = xcfr_pkg::KIND_PAYLOAD;
    res.payload_byte       = '0;
    res.error_code         = xcfr_pkg::ERR_NONE;
    res.frame_length       = '0;
    res.last               = 1'b0;

    if (command == xcfr_pkg::CMD_TICK) begin
      tick_count_next = tick_inc;
      if (tick_inc > cfg.timeout_ticks) begin
        phase_next      = xcfr_pkg::PH_HUNT;
        tick_count_next = '0;
        res_valid       = 1'b1;
        res.kind        = xcfr_pkg::KIND_ERROR;
        res.error_code  = xcfr_pkg::ERR_TIMEOUT;
        res.last        = 1'b1;
      end
    end else begin
      running_xor_next = running_xor ^ rx_byte;
      case (phase)
        xcfr_pkg::PH_HUNT: begin
          if (rx_byte == cfg.start_byte) begin
            running_xor_next = cfg.start_byte;
            phase_next       = xcfr_pkg::PH_SEQ;
          end
        end
        xcfr_pkg::PH_SEQ: begin
          if (rx_byte == expected_sequence) begin
            expected_sequence_next = expected_sequence + 8'd1;
            phase_next             = xcfr_pkg::PH_LEN_HI;
          end else begin
            phase_next = xcfr_pkg::PH_HUNT;
          end
        end
        xcfr_pkg::PH_LEN_HI: begin
          declared_length_next = {rx_byte, 8'h00};
          phase_next           = xcfr_pkg::PH_LEN_LO;
        end
        xcfr_pkg::PH_LEN_LO: begin
          declared_length_next = {declared_length[15:8], rx_byte};
          phase_next           = xcfr_pkg::PH_TOKEN;
        end
        xcfr_pkg::PH_TOKEN: begin
          if (rx_byte == cfg.token_byte) begin
            payload_count_next = '0;
            phase_next = (declared_length == 16'd0) ? xcfr_pkg::PH_CKSUM
                                                    : xcfr_pkg::PH_DATA;
          end else begin
            phase_next = xcfr_pkg::PH_HUNT;
          end
        end
        xcfr_pkg::PH_DATA: begin
          res_valid = 1'b1;
          if (payload_count >= cfg.max_payload) begin
            phase_next      = xcfr_pkg::PH_HUNT;
            tick_count_next = '0;
            res.kind        = xcfr_pkg::KIND_ERROR;
            res.error_code  = xcfr_pkg::ERR_OVERFLOW;
            res.last        = 1'b1;
          end else if (payload_count == 16'd0 && rx_byte == cfg.cksum_error_answer) begin
            phase_next      = xcfr_pkg::PH_HUNT;
            tick_count_next = '0;
            res.kind        = xcfr_pkg::KIND_ERROR;
            res.error_code  = xcfr_pkg::ERR_DEV_CKSUM;
            res.last        = 1'b1;
          end else begin
            payload_count_next = count_inc;
            if (count_inc == declared_length) begin
              phase_next = xcfr_pkg::PH_CKSUM;
            end
            res.payload_byte = rx_byte;
          end
        end
        xcfr_pkg::PH_CKSUM: begin
          phase_next      = xcfr_pkg::PH_HUNT;
          tick_count_next = '0;
          res_valid       = 1'b1;
          res.last        = 1'b1;
          if (running_xor_next == 8'h00) begin
            res.kind         = xcfr_pkg::KIND_ACCEPT;
            res.frame_length = declared_length;
          end else begin
            res.kind       = xcfr_pkg::KIND_ERROR;
            res.error_code = xcfr_pkg::ERR_BAD_CKSUM;
          end
        end
        default: begin
          phase_next = xcfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  `XCFR_ASSERT(a_end_to_hunt, (advance && res_valid && res.last) |=> (phase == xcfr_pkg::PH_HUNT), "frame end did not return to hunt")
  `XCFR_ASSERT(a_count_in_range, (phase == xcfr_pkg::PH_DATA) |-> (payload_count < declared_length), "payload count reached length in data phase")
  `XCFR_ASSERT(a_accept_source, (advance && res_valid && res.kind == xcfr_pkg::KIND_ACCEPT) |-> (phase == xcfr_pkg::PH_CKSUM && running_xor == rx_byte), "accept without zero checksum")

endmodule

@@ hw/rtl/xor_checked_frame_receiver.sv @@
// Path: an accepted item is held in the input register, its result, if any, in the output register.
// Throughput: one item per cycle unless the result side stalls; the input register empties
// whenever the output register is free or being taken, so a result stall holds the input.
// Reset: synchronous, active high; clears the parser state, both register valids and
// loads the configuration reset values. No clearing pass.
`timescale 1ns / 1ps

module xor_checked_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] payload_byte, [10:8] error_code, [26:11] frame_length
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  xcfr_pkg::cfg_t    cfg;
  xcfr_pkg::result_t res;
  xcfr_pkg::result_t out_q;
  logic              res_valid;
  logic              in_valid;
  logic              in_cmd;
  logic [7:0]        in_byte;
  logic              advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser[0];
      in_byte <= s_tdata;
    end
  end

  xcfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  xcfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (advance),
    .command   (in_cmd),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {5'b0, out_q.frame_length, out_q.error_code, out_q.payload_byte};
  assign m_tuser = out_q.kind;
  assign m_tlast = out_q.last;

endmodule
